FILE: src/slid_pkg.sv
// Package with shared types and constants for the sorted list block.
`timescale 1ns / 1ps
package slid_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_DISPLAY = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    STATUS_DONE      = 3'd0,
    STATUS_NOT_FOUND = 3'd1,
    STATUS_EMPTY     = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_ENTRY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [VAL_W-1:0] entry;
    logic                    last;
  } result_t;

  typedef struct packed {
    cell_cmd_t               cmd;
    logic signed [VAL_W-1:0] key;
  } cell_ctrl_t;

endpackage

FILE: src/sorted_list_insert_delete.sv
// Top level of the sorted list: command register, sequencer and cell chain.
//
// A transaction is offered by raising start with request (opcode, value); it is
// taken at a rising edge where start is high and busy is low. Results appear on
// result for exactly one cycle, marked by strobe; result.last flags the final
// result of a transaction. The receiver cannot stall, so results are never held.
// Insert and delete: busy is high for one cycle while the whole cell chain
// shifts at once; the single result shows in the cycle after that, when the
// block is already free for a new transaction. Display: the chain rotates one
// cell per cycle and cell zero streams out, giving one result per stored
// entry; the chain is back in its original order after count rotations, when
// the final entry shows and the block is free. An undefined opcode gives no
// result and frees the block once its execute state ends.
// Reset empties the list (count to zero) and drops any pending result; the
// cell contents are not cleared since only the first count cells are read.
`timescale 1ns / 1ps
module sorted_list_insert_delete (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  slid_pkg::request_t  request,
  output logic                strobe,
  output slid_pkg::result_t   result
);
  import slid_pkg::*;

  state_t                  state;
  state_t                  state_next;
  request_t                req;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        idx_next;
  logic                    strobe_next;
  result_t                 result_next;
  cell_ctrl_t              ctrl;
  logic signed [VAL_W-1:0] head;
  logic                    found;
  logic                    full;
  logic                    empty;
  logic                    idx_last;

  assign busy     = (state != S_IDLE);
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign idx_last = ((CNT_W'(idx) + CNT_W'(1)) == count);

  slid_chain u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .count (count),
    .head  (head),
    .found (found)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((req.opcode == OP_DISPLAY) && !empty) begin
          state_next = S_LIST;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        if (idx_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.cmd           = CELL_HOLD;
    ctrl.key           = req.value;
    count_next         = count;
    idx_next           = idx;
    strobe_next        = 1'b0;
    result_next.status = STATUS_DONE;
    result_next.entry  = '0;
    result_next.last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        idx_next = '0;
      end
      S_EXEC: begin
        unique case (req.opcode)
          OP_INSERT: begin
            strobe_next = 1'b1;
            if (full) begin
              result_next.status = STATUS_FULL;
            end else begin
              ctrl.cmd   = CELL_INSERT;
              count_next = count + CNT_W'(1);
            end
          end
          OP_DELETE: begin
            strobe_next = 1'b1;
            if (empty) begin
              result_next.status = STATUS_EMPTY;
            end else if (!found) begin
              result_next.status = STATUS_NOT_FOUND;
            end else begin
              ctrl.cmd   = CELL_DELETE;
              count_next = count - CNT_W'(1);
            end
          end
          OP_DISPLAY: begin
            idx_next = '0;
            if (empty) begin
              strobe_next        = 1'b1;
              result_next.status = STATUS_EMPTY;
            end
          end
          default: begin
            strobe_next = 1'b0;
          end
        endcase
      end
      S_LIST: begin
        ctrl.cmd           = CELL_ROTATE;
        strobe_next        = 1'b1;
        result_next.status = STATUS_ENTRY;
        result_next.entry  = head;
        result_next.last   = idx_last;
        idx_next           = idx + IDX_W'(1);
      end
      default: begin
        strobe_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    result <= result_next;
    if (start && !busy) begin
      req <= request;
    end
  end

endmodule

FILE: src/slid_cell.sv
// One storage cell of the sorted chain with its compare and shift logic.
`timescale 1ns / 1ps
module slid_cell (
  input  logic                               clk,
  input  slid_pkg::cell_ctrl_t               ctrl,
  input  logic                               valid,
  input  logic                               left_le,
  input  logic signed [slid_pkg::VAL_W-1:0]  left_val,
  input  logic signed [slid_pkg::VAL_W-1:0]  right_val,
  input  logic signed [slid_pkg::VAL_W-1:0]  head_val,
  input  logic                               wrap,
  output logic signed [slid_pkg::VAL_W-1:0]  val,
  output logic                               le,
  output logic                               eq
);
  import slid_pkg::*;

  logic signed [VAL_W-1:0] val_next;
  logic                    ge;

  assign le = valid && (val <= ctrl.key);
  assign ge = valid && (val >= ctrl.key);
  assign eq = valid && (val == ctrl.key);

  always_comb begin
    val_next = val;
    case (ctrl.cmd)
      CELL_INSERT: begin
        // The list is sorted, so the cells that keep their value form a prefix.
        if (!le) begin
          val_next = left_le ? ctrl.key : left_val;
        end
      end
      CELL_DELETE: begin
        if (ge) begin
          val_next = right_val;
        end
      end
      CELL_ROTATE: begin
        val_next = wrap ? head_val : right_val;
      end
      default: begin
        val_next = val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: src/slid_chain.sv
// Row of storage cells wired to their neighbors.
`timescale 1ns / 1ps
module slid_chain (
  input  logic                               clk,
  input  slid_pkg::cell_ctrl_t               ctrl,
  input  logic [slid_pkg::CNT_W-1:0]         count,
  output logic signed [slid_pkg::VAL_W-1:0]  head,
  output logic                               found
);
  import slid_pkg::*;

  logic signed [VAL_W-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0]     le_vec;
  logic [CAPACITY-1:0]     eq_vec;

  assign head  = vals[0];
  assign found = |eq_vec;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    left_le;
    logic signed [VAL_W-1:0] left_val;
    logic signed [VAL_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_le  = 1'b1;
      assign left_val = '0;
    end else begin : g_mid
      assign left_le  = le_vec[i-1];
      assign left_val = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = vals[i+1];
    end

    slid_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .valid     (count > CNT_W'(i)),
      .left_le   (left_le),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (vals[0]),
      .wrap      (count == CNT_W'(i + 1)),
      .val       (vals[i]),
      .le        (le_vec[i]),
      .eq        (eq_vec[i])
    );
  end

endmodule

FILE: src/slid_checker.sv
// Port-level checker for the sorted list, bound to the top level.
`timescale 1ns / 1ps
module slid_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               strobe,
  input slid_pkg::result_t  result
);
  import slid_pkg::*;

  // A transaction that is taken always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted transaction");

  // Every result other than a listed entry is a single, final result with zero entry.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.status != STATUS_ENTRY) |-> result.last && (result.entry == '0))
    else $error("status result is not final or carries an entry");

  // A display stream has no gaps until its final entry.
  a_stream_gapless: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.status == STATUS_ENTRY) && !result.last |=>
      strobe && (result.status == STATUS_ENTRY))
    else $error("display stream broke before its final entry");

  // The block is free again once the final result of a transaction shows.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> !busy)
    else $error("block still busy on the final result");

endmodule

bind sorted_list_insert_delete slid_checker u_slid_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);
